@@ design/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define CHK_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

@@ design/gdo_pkg.sv @@
package gdo_pkg;

  localparam int COUNT_BITS_DEF = 16;

  localparam int YEAR_W    = 14;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int WEEKDAY_W = 3;
  localparam int STATUS_W  = 2;
  localparam int CMD_W     = 2;
  localparam int Q100_W    = 8;
  localparam int Q7_W      = 12;

  localparam logic [CMD_W-1:0] CMD_SET     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BACK    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;

  // Reciprocal constants: x / 100 = (x * 5243) >> 19 for x below 2^14,
  // x / 7 = (x * 18725) >> 17 for x below 2^14.
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam logic [14:0] DIV7_MUL     = 15'd18725;
  localparam int          DIV7_SHIFT   = 17;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_LEAP,
    S_DISPATCH,
    S_SETCHK,
    S_FWD,
    S_BCHK,
    S_BADD,
    S_COMMIT,
    S_WDIV,
    S_DOY,
    S_WSUM,
    S_WQ7,
    S_WMOD
  } state_t;

  typedef struct packed {
    logic load;
    logic div_y;
    logic div_p;
    logic leap;
    logic fwd_step;
    logic back_step;
    logic back_add;
    logic set_range;
    logic set_invalid;
    logic commit;
    logic doy_init;
    logic doy_step;
    logic wk_sum;
    logic wk_q7;
    logic wk_mod;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             fwd_more;
    logic             d_le_zero;
    logic             wrap_fwd;
    logic             wrap_back;
    logic             year_top;
    logic             year_bottom;
    logic             set_valid;
    logic             doy_more;
  } dp_stat_t;

  function automatic logic [DAY_W-1:0] days_in_month(input logic leap,
                                                      input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // The quotient q is the year divided by 100, taken from a register.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y, input logic [Q100_W-1:0] q);
    logic [YEAR_W+6:0] hundreds;
    logic              whole;
    hundreds = {{(YEAR_W-1){1'b0}}, q} * 7'd100;
    whole    = (hundreds == {7'd0, y});
    return ((y[1:0] == 2'd0) && !whole) || (whole && (q[1:0] == 2'd0));
  endfunction

endpackage

@@ design/gdo_ctrl.sv @@
module gdo_ctrl
  import gdo_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  state_t state, state_next;
  state_t ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          ret_next   = S_DISPATCH;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_y  = 1'b1;
        state_next = S_LEAP;
      end
      S_LEAP: begin
        cmd.leap   = 1'b1;
        state_next = ret;
      end
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_SET:     state_next = S_SETCHK;
          CMD_ADVANCE: state_next = S_FWD;
          CMD_BACK:    state_next = S_BCHK;
          default:     state_next = S_COMMIT;
        endcase
      end
      S_SETCHK: begin
        cmd.set_invalid = !stat.set_valid;
        state_next      = S_COMMIT;
      end
      S_FWD: begin
        if (!stat.fwd_more) begin
          state_next = S_COMMIT;
        end else if (stat.wrap_fwd && stat.year_top) begin
          cmd.set_range = 1'b1;
          state_next    = S_COMMIT;
        end else if (stat.wrap_fwd) begin
          cmd.fwd_step = 1'b1;
          ret_next     = S_FWD;
          state_next   = S_DIV;
        end else begin
          cmd.fwd_step = 1'b1;
        end
      end
      S_BCHK: begin
        if (!stat.d_le_zero) begin
          state_next = S_COMMIT;
        end else if (stat.wrap_back && stat.year_bottom) begin
          cmd.set_range = 1'b1;
          state_next    = S_COMMIT;
        end else if (stat.wrap_back) begin
          cmd.back_step = 1'b1;
          ret_next      = S_BADD;
          state_next    = S_DIV;
        end else begin
          cmd.back_step = 1'b1;
          state_next    = S_BADD;
        end
      end
      S_BADD: begin
        cmd.back_add = 1'b1;
        state_next   = S_BCHK;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        ret_next   = S_WDIV;
        state_next = S_DIV;
      end
      S_WDIV: begin
        cmd.div_p    = 1'b1;
        cmd.doy_init = 1'b1;
        state_next   = S_DOY;
      end
      S_DOY: begin
        if (stat.doy_more) begin
          cmd.doy_step = 1'b1;
        end else begin
          state_next = S_WSUM;
        end
      end
      S_WSUM: begin
        cmd.wk_sum = 1'b1;
        state_next = S_WQ7;
      end
      S_WQ7: begin
        cmd.wk_q7  = 1'b1;
        state_next = S_WMOD;
      end
      S_WMOD: begin
        cmd.wk_mod = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/gdo_dp.sv @@
module gdo_dp
  import gdo_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [CMD_W-1:0]      command,
  input  logic [YEAR_W-1:0]     set_year,
  input  logic [MONTH_W-1:0]    set_month,
  input  logic [DAY_W-1:0]      set_day,
  input  logic [COUNT_BITS-1:0] day_count,
  output logic                  done,
  output logic [YEAR_W-1:0]     year,
  output logic [MONTH_W-1:0]    month,
  output logic [DAY_W-1:0]      day,
  output logic [WEEKDAY_W-1:0]  weekday,
  output logic [STATUS_W-1:0]   status
);

  localparam int DW = COUNT_BITS + 2;

  logic [YEAR_W-1:0]    cur_year;
  logic [MONTH_W-1:0]   cur_month;
  logic [DAY_W-1:0]     cur_day;

  logic [CMD_W-1:0]     op;
  logic [STATUS_W-1:0]  st;
  logic [YEAR_W-1:0]    wy;
  logic [MONTH_W-1:0]   wm;
  logic signed [DW-1:0] wd;
  logic                 wleap;
  logic [Q100_W-1:0]    q100;
  logic [MONTH_W-1:0]   mi;
  logic [YEAR_W-1:0]    acc;
  logic [Q7_W-1:0]      q7;

  logic [YEAR_W-1:0]    div_in;
  logic [YEAR_W+12:0]   div_prod;
  logic [YEAR_W+14:0]   mod_prod;
  logic [DAY_W-1:0]     dim;
  logic signed [DW-1:0] dim_w;
  logic signed [DW-1:0] cur_day_w;
  logic signed [DW-1:0] count_w;
  logic [YEAR_W-1:0]    prev_year;
  logic [YEAR_W-1:0]    q7_x7;
  logic [YEAR_W-1:0]    rem7;

  assign div_in    = cmd.div_p ? prev_year : wy;
  assign div_prod  = {13'd0, div_in} * {{YEAR_W{1'b0}}, DIV100_MUL};
  assign mod_prod  = {15'd0, acc} * {{YEAR_W{1'b0}}, DIV7_MUL};
  assign dim       = days_in_month(wleap, wm);
  assign dim_w     = $signed({{(DW-DAY_W){1'b0}}, dim});
  assign cur_day_w = $signed({{(DW-DAY_W){1'b0}}, cur_day});
  assign count_w   = $signed({2'b00, day_count});
  assign prev_year = wy - YEAR_MIN;
  assign q7_x7     = ({{(YEAR_W-Q7_W){1'b0}}, q7} << 3) - {{(YEAR_W-Q7_W){1'b0}}, q7};
  assign rem7      = acc - q7_x7;

  always_comb begin
    stat.cmd         = op;
    stat.fwd_more    = (wd > dim_w);
    stat.d_le_zero   = wd[DW-1] || (wd == '0);
    stat.wrap_fwd    = (wm == MONTH_LAST);
    stat.wrap_back   = (wm == MONTH_FIRST);
    stat.year_top    = (wy == YEAR_MAX);
    stat.year_bottom = (wy == YEAR_MIN);
    stat.set_valid   = (wy >= YEAR_MIN) && (wy <= YEAR_MAX) &&
                       (wm >= MONTH_FIRST) && (wm <= MONTH_LAST) &&
                       (wd >= $signed({{(DW-DAY_W){1'b0}}, DAY_FIRST})) && (wd <= dim_w);
    stat.doy_more    = (mi < wm);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_year  <= YEAR_MIN;
      cur_month <= MONTH_FIRST;
      cur_day   <= DAY_FIRST;
      done      <= 1'b0;
    end else begin
      done <= cmd.wk_mod;
      if (cmd.commit && (st == ST_OK)) begin
        cur_year  <= wy;
        cur_month <= wm;
        cur_day   <= wd[DAY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= command;
      st <= ST_OK;
      if (command == CMD_SET) begin
        wy <= set_year;
        wm <= set_month;
        wd <= $signed({{(DW-DAY_W){1'b0}}, set_day});
      end else begin
        wy <= cur_year;
        wm <= cur_month;
        if (command == CMD_ADVANCE) begin
          wd <= cur_day_w + count_w;
        end else if (command == CMD_BACK) begin
          wd <= cur_day_w - count_w;
        end else begin
          wd <= cur_day_w;
        end
      end
    end
    if (cmd.set_range) begin
      st <= ST_RANGE;
    end
    if (cmd.set_invalid) begin
      st <= ST_INVALID;
    end
    if (cmd.div_y || cmd.div_p) begin
      q100 <= div_prod[DIV100_SHIFT +: Q100_W];
    end
    if (cmd.leap) begin
      wleap <= is_leap(wy, q100);
    end
    if (cmd.fwd_step) begin
      wd <= wd - dim_w;
      if (wm == MONTH_LAST) begin
        wm <= MONTH_FIRST;
        wy <= wy + YEAR_MIN;
      end else begin
        wm <= wm + MONTH_FIRST;
      end
    end
    if (cmd.back_step) begin
      if (wm == MONTH_FIRST) begin
        wm <= MONTH_LAST;
        wy <= wy - YEAR_MIN;
      end else begin
        wm <= wm - MONTH_FIRST;
      end
    end
    if (cmd.back_add) begin
      wd <= wd + dim_w;
    end
    if (cmd.commit && (st != ST_OK)) begin
      wy <= cur_year;
      wm <= cur_month;
      wd <= cur_day_w;
    end
    if (cmd.doy_init) begin
      mi  <= MONTH_FIRST;
      acc <= {{(YEAR_W-DAY_W){1'b0}}, wd[DAY_W-1:0]};
      wm  <= wm;
    end
    if (cmd.doy_step) begin
      acc <= acc + {{(YEAR_W-DAY_W){1'b0}}, days_in_month(wleap, mi)};
      mi  <= mi + MONTH_FIRST;
    end
    if (cmd.wk_sum) begin
      acc <= acc + prev_year + (prev_year >> 2) - {{(YEAR_W-Q100_W){1'b0}}, q100}
             + {{(YEAR_W-Q100_W){1'b0}}, (q100 >> 2)};
    end
    if (cmd.wk_q7) begin
      q7 <= mod_prod[DIV7_SHIFT +: Q7_W];
    end
    if (cmd.wk_mod) begin
      year    <= cur_year;
      month   <= cur_month;
      day     <= cur_day;
      weekday <= rem7[WEEKDAY_W-1:0];
      status  <= st;
    end
  end

endmodule

@@ design/gregorian_date_offset.sv @@
// A command loads the working date, checks or walks it, commits it, then counts the day of
// the year and the weekday before the done beat. A forward move steps one month at a time,
// a backward move steps one month and then adds that month's length, and each year crossed
// recomputes the leap flag.
// One command at a time; the next start beat is taken in the cycle done pulses, and the
// receiver cannot stall. Synchronous reset loads 0001-01-01, clears done and idles the block.
module gregorian_date_offset
  import gdo_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      command,
  input  logic [YEAR_W-1:0]     set_year,
  input  logic [MONTH_W-1:0]    set_month,
  input  logic [DAY_W-1:0]      set_day,
  input  logic [COUNT_BITS-1:0] day_count,
  output logic                  done,
  output logic [YEAR_W-1:0]     year,
  output logic [MONTH_W-1:0]    month,
  output logic [DAY_W-1:0]      day,
  output logic [WEEKDAY_W-1:0]  weekday,
  output logic [STATUS_W-1:0]   status
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  gdo_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (dp_stat),
    .cmd   (dp_cmd),
    .busy  (busy)
  );

  gdo_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .command   (command),
    .set_year  (set_year),
    .set_month (set_month),
    .set_day   (set_day),
    .day_count (day_count),
    .done      (done),
    .year      (year),
    .month     (month),
    .day       (day),
    .weekday   (weekday),
    .status    (status)
  );

endmodule

@@ design/gdo_checker.sv @@
`include "assert_macros.svh"

module gdo_checker
  import gdo_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic [MONTH_W-1:0]   month,
  input logic [DAY_W-1:0]     day,
  input logic [WEEKDAY_W-1:0] weekday,
  input logic [STATUS_W-1:0]  status
);

  // An accepted beat always starts a multi-cycle walk.
  `CHK_NEXT(a_start_busy, clk, rst, start && !busy, busy, "accepted beat did not raise busy")
  // The result beat arrives only once the block has gone idle.
  `CHK_IMPLY(a_done_idle, clk, rst, done, !busy, "result beat while busy")
  // Each result beat lasts exactly one cycle.
  `CHK_NEXT(a_done_pulse, clk, rst, done, !done, "result beat held for two cycles")
  // A reported date has a month in range, a nonzero day, a valid weekday and a defined status.
  `CHK_IMPLY(a_date_sane, clk, rst, done,
             (month >= MONTH_FIRST) && (month <= MONTH_LAST) && (day >= DAY_FIRST) &&
             (weekday <= 3'd6) && (status != 2'd3), "reported date out of range")

endmodule

bind gregorian_date_offset gdo_checker u_gdo_checker (.*);

@@ tb/sv/testbench.sv @@
module testbench;
  import gdo_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 235;
  localparam int CALM_ITEMS = 40;

  class date_scoreboard;
    typedef struct {
      logic [YEAR_W-1:0]    y;
      logic [MONTH_W-1:0]   m;
      logic [DAY_W-1:0]     d;
      logic [WEEKDAY_W-1:0] wd;
      logic [STATUS_W-1:0]  st;
    } date_result_t;

    int unsigned  now_y;
    int unsigned  now_m;
    int unsigned  now_d;
    date_result_t pending_dates[$];
    int           errors;

    function new();
      now_y  = 1;
      now_m  = 1;
      now_d  = 1;
      errors = 0;
    endfunction

    function bit is_leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int unsigned month_days(int unsigned y, int unsigned m);
      case (m)
        2:            return is_leap_year(y) ? 29 : 28;
        4, 6, 9, 11:  return 30;
        default:      return 31;
      endcase
    endfunction

    function int unsigned day_of_week(int unsigned y, int unsigned m, int unsigned d);
      int unsigned doy;
      int unsigned p;
      doy = d;
      for (int unsigned i = 1; i < m; i++) doy += month_days(y, i);
      p = y - 1;
      return (p + p / 4 - p / 100 + p / 400 + doy) % 7;
    endfunction

    // Predicts the date after one accepted command beat and queues it.
    function void note_command(logic [CMD_W-1:0] cmd, logic [YEAR_W-1:0] sy,
                               logic [MONTH_W-1:0] sm, logic [DAY_W-1:0] sd,
                               logic [15:0] n);
      int unsigned  y;
      int unsigned  m;
      int           d;
      bit           in_range;
      date_result_t r;
      y = now_y;
      m = now_m;
      d = now_d;
      in_range = 1'b1;
      r.st = ST_OK;
      if (cmd == CMD_SET) begin
        if (sy >= YEAR_MIN && sy <= YEAR_MAX && sm >= MONTH_FIRST && sm <= MONTH_LAST &&
            sd >= DAY_FIRST && sd <= month_days(32'(sy), 32'(sm))) begin
          y = 32'(sy);
          m = 32'(sm);
          d = int'(sd);
        end else begin
          r.st = ST_INVALID;
        end
      end else if (cmd == CMD_ADVANCE) begin
        d = d + int'(n);
        while (in_range && d > int'(month_days(y, m))) begin
          d -= month_days(y, m);
          m++;
          if (m == 13) begin
            m = 1;
            y++;
            if (y > YEAR_MAX) in_range = 1'b0;
          end
        end
        if (!in_range) r.st = ST_RANGE;
      end else if (cmd == CMD_BACK) begin
        d = d - int'(n);
        while (in_range && d <= 0) begin
          m--;
          if (m == 0) begin
            m = 12;
            y--;
            if (y < YEAR_MIN) in_range = 1'b0;
          end
          if (in_range) d += month_days(y, m);
        end
        if (!in_range) r.st = ST_RANGE;
      end
      if (r.st == ST_OK) begin
        now_y = y;
        now_m = m;
        now_d = d;
      end
      r.y  = YEAR_W'(now_y);
      r.m  = MONTH_W'(now_m);
      r.d  = DAY_W'(now_d);
      r.wd = WEEKDAY_W'(day_of_week(now_y, now_m, now_d));
      pending_dates.push_back(r);
    endfunction

    function int outstanding();
      return pending_dates.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m, logic [DAY_W-1:0] d,
                      logic [WEEKDAY_W-1:0] wd, logic [STATUS_W-1:0] st);
      date_result_t w;
      if (pending_dates.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d-%0d-%0d", y, m, d));
        return;
      end
      w = pending_dates.pop_front();
      if (y !== w.y) report_mismatch($sformatf("year %0d, want %0d", y, w.y));
      if (m !== w.m) report_mismatch($sformatf("month %0d, want %0d", m, w.m));
      if (d !== w.d) report_mismatch($sformatf("day %0d, want %0d", d, w.d));
      if (wd !== w.wd) report_mismatch($sformatf("weekday %0d, want %0d", wd, w.wd));
      if (st !== w.st) report_mismatch($sformatf("status %0d, want %0d", st, w.st));
    endtask
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     command = CMD_UNUSED;
  logic [YEAR_W-1:0]    set_year = '0;
  logic [MONTH_W-1:0]   set_month = '0;
  logic [DAY_W-1:0]     set_day = '0;
  logic [15:0]          day_count = '0;
  logic                 done;
  logic [YEAR_W-1:0]    year;
  logic [MONTH_W-1:0]   month;
  logic [DAY_W-1:0]     day;
  logic [WEEKDAY_W-1:0] weekday;
  logic [STATUS_W-1:0]  status;

  date_scoreboard sb = new();

  gregorian_date_offset i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .set_year  (set_year),
    .set_month (set_month),
    .set_day   (set_day),
    .day_count (day_count),
    .done      (done),
    .year      (year),
    .month     (month),
    .day       (day),
    .weekday   (weekday),
    .status    (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(year, month, day, weekday, status);
  end

  task automatic send_command(logic [CMD_W-1:0] cmd, int unsigned sy, int unsigned sm,
                              int unsigned sd, int unsigned n);
    start     <= 1'b1;
    command   <= cmd;
    set_year  <= sy[YEAR_W-1:0];
    set_month <= sm[MONTH_W-1:0];
    set_day   <= sd[DAY_W-1:0];
    day_count <= n[15:0];
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_command(cmd, sy[YEAR_W-1:0], sm[MONTH_W-1:0], sd[DAY_W-1:0], n[15:0]);
  endtask

  task automatic pause(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic random_command();
    logic [CMD_W-1:0] cmd;
    int unsigned      pick;
    int unsigned      sel;
    int unsigned      sy;
    int unsigned      sm;
    int unsigned      sd;
    int unsigned      n;
    pick = $urandom_range(0, 99);
    sy = $urandom_range(0, 16383);
    sm = $urandom_range(0, 15);
    sd = $urandom_range(0, 31);
    sel = $urandom_range(0, 9);
    if (sel < 7) n = $urandom_range(0, 400);
    else if (sel < 9) n = $urandom_range(0, 5000);
    else n = $urandom_range(0, 65535);
    if (pick < 25) begin
      cmd = CMD_SET;
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
        if (sel < 6) sy = $urandom_range(1, 9999);
        else if (sel == 6) sy = $urandom_range(1, 4);
        else sy = $urandom_range(9996, 9999);
        sm = $urandom_range(1, 12);
        sd = $urandom_range(1, sb.month_days(sy, sm));
      end
    end else if (pick < 60) begin
      cmd = CMD_ADVANCE;
    end else if (pick < 95) begin
      cmd = CMD_BACK;
    end else begin
      cmd = CMD_UNUSED;
    end
    send_command(cmd, sy, sm, sd, n);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_command(CMD_UNUSED, 16383, 15, 31, 65535);
    send_command(CMD_ADVANCE, 0, 0, 0, 0);
    send_command(CMD_BACK, 0, 0, 0, 1);
    send_command(CMD_BACK, 0, 0, 0, 65535);
    send_command(CMD_SET, 9999, 12, 31, 0);
    send_command(CMD_ADVANCE, 0, 0, 0, 1);
    send_command(CMD_SET, 2000, 2, 29, 0);
    send_command(CMD_SET, 1900, 2, 29, 0);
    send_command(CMD_SET, 2023, 2, 29, 0);
    send_command(CMD_SET, 2024, 2, 29, 0);
    send_command(CMD_ADVANCE, 0, 0, 0, 65535);
    send_command(CMD_BACK, 0, 0, 0, 65535);
    send_command(CMD_SET, 0, 6, 15, 0);
    send_command(CMD_SET, 10000, 6, 15, 0);
    send_command(CMD_SET, 2010, 0, 15, 0);
    send_command(CMD_SET, 2010, 13, 15, 0);
    send_command(CMD_SET, 2010, 6, 0, 0);
    send_command(CMD_SET, 2010, 4, 31, 0);
    send_command(CMD_SET, 9999, 1, 1, 0);
    send_command(CMD_ADVANCE, 0, 0, 0, 364);
    send_command(CMD_SET, 1, 1, 1, 0);
    send_command(CMD_ADVANCE, 0, 0, 0, 65535);
    send_command(CMD_BACK, 0, 0, 0, 65535);
    send_command(CMD_SET, 1, 3, 1, 0);
    send_command(CMD_BACK, 0, 0, 0, 60);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 15));
      random_command();
    end
    start <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/gdo_pkg.sv
design/gdo_ctrl.sv
design/gdo_dp.sv
design/gregorian_date_offset.sv
design/gdo_checker.sv
tb/sv/testbench.sv
